/* rtl/flht_pkg.sv */
// Package with the shared types and constants of the fan level hysteresis table.
`default_nettype none

package flht_pkg;

  // Level encoding and the top of the table.
  localparam int LVL_W = 3;
  localparam int NUM_LEVELS = 8;
  localparam logic [LVL_W-1:0] LEVEL_TOP = LVL_W'(NUM_LEVELS - 1);

  // Field widths.
  localparam int TEMP_W = 8;
  localparam int CHAN_W = 2;
  localparam int PWR_W = 2;
  localparam int RPM_W = 16;
  localparam int REG_W = 32;
  localparam int IDX_W = 3;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  // Power state codes.
  localparam logic [PWR_W-1:0] PWR_RUNNING = 2'd1;
  localparam logic [PWR_W-1:0] PWR_SUSPENDED = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ON_LOW = 3'd0;
  localparam logic [IDX_W-1:0] REG_ON_HIGH = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFF_LOW = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPEED_01 = 3'd4;
  localparam logic [IDX_W-1:0] REG_SPEED_23 = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPEED_45 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPEED_67 = 3'd7;

  // Default fan table loaded at reset.
  localparam logic [REG_W-1:0] RST_ON_LOW = 32'd740894244;
  localparam logic [REG_W-1:0] RST_ON_HIGH = 32'd926101806;
  localparam logic [REG_W-1:0] RST_OFF_LOW = 32'd707208192;
  localparam logic [REG_W-1:0] RST_OFF_HIGH = 32'd875638572;
  localparam logic [REG_W-1:0] RST_SPEED_01 = 32'd131072000;
  localparam logic [REG_W-1:0] RST_SPEED_23 = 32'd196610600;
  localparam logic [REG_W-1:0] RST_SPEED_45 = 32'd235932900;
  localparam logic [REG_W-1:0] RST_SPEED_67 = 32'd308023400;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIR,
    S_WALK,
    S_RESULT
  } seq_state_t;

  // Operand the shared comparator looks at.
  typedef enum logic [1:0] {
    CMP_PREV,
    CMP_ON,
    CMP_OFF
  } cmp_mode_t;

  // Walk direction.
  typedef enum logic {
    DIR_UP,
    DIR_DOWN
  } walk_dir_t;

  // Comparator result: sample below or above the selected operand.
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

/* rtl/flht_cmp_unit.sv */
// Shared signed comparator with threshold selection for the level walk.
`default_nettype none

module flht_cmp_unit
  import flht_pkg::*;
(
  input  wire logic [TEMP_W-1:0] temperature,
  input  wire logic [TEMP_W-1:0] prev_temperature,
  input  wire logic [LVL_W-1:0]  level,
  input  wire cmp_mode_t         mode,
  input  wire logic [REG_W-1:0]  on_low,
  input  wire logic [REG_W-1:0]  on_high,
  input  wire logic [REG_W-1:0]  off_low,
  input  wire logic [REG_W-1:0]  off_high,
  output cmp_res_t               res
);

  logic [REG_W-1:0]         thr_word;
  logic signed [TEMP_W-1:0] operand;
  logic signed [TEMP_W-1:0] sample;

  // Pick the threshold byte of the current level, or the previous sample.
  always_comb begin
    thr_word = '0;
    operand = '0;
    case (mode)
      CMP_ON: begin
        thr_word = level[2] ? on_high : on_low;
        operand = signed'(thr_word[level[1:0]*TEMP_W +: TEMP_W]);
      end
      CMP_OFF: begin
        thr_word = level[2] ? off_high : off_low;
        operand = signed'(thr_word[level[1:0]*TEMP_W +: TEMP_W]);
      end
      CMP_PREV: begin
        operand = signed'(prev_temperature);
      end
      default: begin
        operand = '0;
      end
    endcase
  end

  // One signed compare serves every step.
  assign sample = signed'(temperature);
  assign res.lt = (sample < operand);
  assign res.gt = (sample > operand);

endmodule

`default_nettype wire

/* rtl/fan_level_hysteresis_table.sv */
// Top level of the fan level table with hysteresis.
`default_nettype none

// A sample transfer on the slave side carries a temperature, a fan channel and
// the power state. In the running state the block compares the sample with the
// previous one and then walks the kept fan level one step per cycle through a
// single shared comparator, then gives the level and its RPM (zero for any
// channel but 0). In the suspended state it gives RPM zero without changing
// state; other power states give no result. A suspended sample goes from the
// transfer to the result step. A running one passes the direction step and, when
// the temperature changed, the walk of at most seven level steps; the result
// step waits while the output register is full. The slave side is ready again
// in the cycle after the result register loads. The block takes the next sample
// while a finished result still waits on the master side.
module fan_level_hysteresis_table
  import flht_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Sample input.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [7:0] temperature, [9:8] fan_index, [11:10] power_state, rest zero.
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // Result output.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [1:0] fan_channel, [17:2] rpm_target, [20:18] new_level, rest zero.
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // Configuration writes.
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [REG_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [REG_W-1:0] on_low;
  logic [REG_W-1:0] on_high;
  logic [REG_W-1:0] off_low;
  logic [REG_W-1:0] off_high;
  logic [REG_W-1:0] speed_01;
  logic [REG_W-1:0] speed_23;
  logic [REG_W-1:0] speed_45;
  logic [REG_W-1:0] speed_67;

  // Kept state.
  logic [LVL_W-1:0]  fan_level;
  logic [TEMP_W-1:0] prev_temperature;

  // Sequencer registers.
  seq_state_t        state;
  seq_state_t        state_next;
  walk_dir_t         dir;
  walk_dir_t         dir_next;
  logic [LVL_W-1:0]  lvl_work;
  logic [LVL_W-1:0]  lvl_work_next;
  logic [TEMP_W-1:0] temp_q;
  logic [CHAN_W-1:0] chan_q;
  logic [PWR_W-1:0]  pwr_q;

  // Output register.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Control.
  logic             in_xfer;
  logic             out_free;
  logic             load_out;
  logic             commit;
  cmp_mode_t        mode;
  cmp_res_t         cmp;
  logic [LVL_W-1:0] level_clamped;
  logic [REG_W-1:0] speed_word;
  logic [RPM_W-1:0] rpm;

  assign s_tready = (state == S_IDLE);
  assign in_xfer = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;
  assign level_clamped = (fan_level > LEVEL_TOP) ? LEVEL_TOP : fan_level;

  // Shared comparator.
  flht_cmp_unit u_cmp (
    .temperature      (temp_q),
    .prev_temperature (prev_temperature),
    .level            (lvl_work),
    .mode             (mode),
    .on_low           (on_low),
    .on_high          (on_high),
    .off_low          (off_low),
    .off_high         (off_high),
    .res              (cmp)
  );

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_low <= RST_ON_LOW;
      on_high <= RST_ON_HIGH;
      off_low <= RST_OFF_LOW;
      off_high <= RST_OFF_HIGH;
      speed_01 <= RST_SPEED_01;
      speed_23 <= RST_SPEED_23;
      speed_45 <= RST_SPEED_45;
      speed_67 <= RST_SPEED_67;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_LOW: on_low <= cfg_data;
        REG_ON_HIGH: on_high <= cfg_data;
        REG_OFF_LOW: off_low <= cfg_data;
        REG_OFF_HIGH: off_high <= cfg_data;
        REG_SPEED_01: speed_01 <= cfg_data;
        REG_SPEED_23: speed_23 <= cfg_data;
        REG_SPEED_45: speed_45 <= cfg_data;
        REG_SPEED_67: speed_67 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Next state, comparator operand and level steps.
  always_comb begin
    state_next = state;
    dir_next = dir;
    lvl_work_next = lvl_work;
    mode = CMP_PREV;
    load_out = 1'b0;
    commit = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          lvl_work_next = level_clamped;
          if (s_tdata[11:10] == PWR_RUNNING) begin
            state_next = S_DIR;
          end else if (s_tdata[11:10] == PWR_SUSPENDED) begin
            state_next = S_RESULT;
          end
        end
      end
      S_DIR: begin
        mode = CMP_PREV;
        if (cmp.lt) begin
          dir_next = DIR_DOWN;
          state_next = S_WALK;
        end else if (cmp.gt) begin
          dir_next = DIR_UP;
          state_next = S_WALK;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_WALK: begin
        if (dir == DIR_DOWN) begin
          mode = CMP_OFF;
          if (lvl_work != '0 && cmp.lt) begin
            lvl_work_next = lvl_work - LVL_W'(1);
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          mode = CMP_ON;
          if (lvl_work < LEVEL_TOP && cmp.gt) begin
            lvl_work_next = lvl_work + LVL_W'(1);
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          load_out = 1'b1;
          commit = (pwr_q == PWR_RUNNING);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dir <= DIR_UP;
      lvl_work <= '0;
    end else begin
      state <= state_next;
      dir <= dir_next;
      lvl_work <= lvl_work_next;
    end
  end

  // Sample capture.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      temp_q <= s_tdata[7:0];
      chan_q <= s_tdata[9:8];
      pwr_q <= s_tdata[11:10];
    end
  end

  // Kept level and previous sample update when a running result leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_level <= '0;
      prev_temperature <= '0;
    end else if (commit) begin
      fan_level <= lvl_work;
      prev_temperature <= temp_q;
    end
  end

  // RPM of the reached level, channel 0 in the running state only.
  always_comb begin
    case (lvl_work[2:1])
      2'd0: speed_word = speed_01;
      2'd1: speed_word = speed_23;
      2'd2: speed_word = speed_45;
      2'd3: speed_word = speed_67;
      default: speed_word = speed_01;
    endcase
    if (pwr_q == PWR_RUNNING && chan_q == '0) begin
      rpm = lvl_work[0] ? speed_word[REG_W-1:RPM_W] : speed_word[RPM_W-1:0];
    end else begin
      rpm = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {3'b000, lvl_work, rpm, chan_q};
    end
  end

  // The kept level never leaves the table.
  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    fan_level <= LEVEL_TOP)
    else $error("fan level beyond the top of the table");

  // The working level stays inside the table during a walk.
  a_work_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (lvl_work <= LEVEL_TOP))
    else $error("working level beyond the top of the table");

  // The kept state changes only when a result is loaded.
  a_state_commit: assert property (@(posedge clk) disable iff (rst)
    (state != S_RESULT) |=> ($stable(fan_level) && $stable(prev_temperature)))
    else $error("kept state changed outside the result step");

  // An upward walk never lowers the level.
  a_walk_up: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && dir == DIR_UP) |=> (lvl_work >= $past(lvl_work)))
    else $error("upward walk lowered the level");

  // A new result appears only out of the result step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_RESULT))
    else $error("result shown without passing the result step");

endmodule

`default_nettype wire

/* tb/sv/flht_tb_pkg.sv */
// Scoreboard class that predicts and checks the fan level table results.
`timescale 1ns / 1ps

package flht_tb_pkg;
  import flht_pkg::*;

  // Power state codes that the block leaves without a result.
  localparam logic [PWR_W-1:0] PWR_OTHER = 2'd0;
  localparam logic [PWR_W-1:0] PWR_UNUSED = 2'd3;

  localparam int NUM_REGS = 8;
  localparam int MAX_PRINTED = 40;

  // One fan target as it should leave the block.
  typedef struct packed {
    logic [CHAN_W-1:0] fan_channel;
    logic [RPM_W-1:0]  rpm_target;
    logic [LVL_W-1:0]  new_level;
  } fan_target_t;

  class level_table_scoreboard;
    logic [REG_W-1:0]         regs [NUM_REGS];
    logic [LVL_W-1:0]         fan_level;
    logic signed [TEMP_W-1:0] last_temp;
    fan_target_t              expected_targets [$];
    int                       mismatches;
    int                       checked;
    int                       top_hits;
    int                       floor_hits;

    // Start from the table and state that the block holds after reset.
    function new();
      regs[REG_ON_LOW] = RST_ON_LOW;
      regs[REG_ON_HIGH] = RST_ON_HIGH;
      regs[REG_OFF_LOW] = RST_OFF_LOW;
      regs[REG_OFF_HIGH] = RST_OFF_HIGH;
      regs[REG_SPEED_01] = RST_SPEED_01;
      regs[REG_SPEED_23] = RST_SPEED_23;
      regs[REG_SPEED_45] = RST_SPEED_45;
      regs[REG_SPEED_67] = RST_SPEED_67;
      fan_level = '0;
      last_temp = '0;
      mismatches = 0;
      checked = 0;
      top_hits = 0;
      floor_hits = 0;
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [REG_W-1:0] value);
      regs[idx] = value;
    endfunction

    function int pending();
      return expected_targets.size();
    endfunction

    // Signed byte threshold of a level; low_reg selects the on or the off pair.
    function logic signed [TEMP_W-1:0] threshold_of(logic [IDX_W-1:0] low_reg,
                                                    logic [LVL_W-1:0] lvl);
      logic [REG_W-1:0] word;
      word = regs[low_reg + lvl[2]];
      return $signed(word[lvl[1:0]*TEMP_W +: TEMP_W]);
    endfunction

    // RPM of a level: even levels in the low half, odd levels in the high half.
    function logic [RPM_W-1:0] rpm_of(logic [LVL_W-1:0] lvl);
      logic [REG_W-1:0] word;
      word = regs[REG_SPEED_01 + lvl[2:1]];
      return lvl[0] ? word[2*RPM_W-1:RPM_W] : word[RPM_W-1:0];
    endfunction

    // Walk the fan level for one accepted sample and queue the target it gives.
    function void note_sample(logic signed [TEMP_W-1:0] temp, logic [CHAN_W-1:0] chan,
                              logic [PWR_W-1:0] pwr);
      logic [LVL_W-1:0] lvl;
      fan_target_t      target;
      lvl = fan_level;
      if (pwr == PWR_RUNNING) begin
        if (temp < last_temp) begin
          while (lvl != '0 && temp < threshold_of(REG_OFF_LOW, lvl))
            lvl--;
          if (lvl == '0)
            floor_hits++;
        end else if (temp > last_temp) begin
          while (lvl != LEVEL_TOP && temp > threshold_of(REG_ON_LOW, lvl))
            lvl++;
          if (lvl == LEVEL_TOP)
            top_hits++;
        end
        fan_level = lvl;
        last_temp = temp;
        target.rpm_target = (chan == '0) ? rpm_of(lvl) : '0;
      end else if (pwr == PWR_SUSPENDED) begin
        target.rpm_target = '0;
      end else begin
        return;
      end
      target.fan_channel = chan;
      target.new_level = lvl;
      expected_targets.push_back(target);
    endfunction

    // Print one line per mismatch (up to a cap) and count every one.
    task report(string msg);
      if (mismatches < MAX_PRINTED)
        $display("tb_top: mismatch on result %0d: %s", checked, msg);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest queued target.
    task check_result(logic [OUT_DATA_W-1:0] data);
      fan_target_t       want;
      logic [CHAN_W-1:0] chan;
      logic [RPM_W-1:0]  rpm;
      logic [LVL_W-1:0]  lvl;
      chan = data[CHAN_W-1:0];
      rpm = data[CHAN_W +: RPM_W];
      lvl = data[CHAN_W+RPM_W +: LVL_W];
      checked++;
      if (expected_targets.size() == 0) begin
        report($sformatf("no target pending, got data %h", data));
        return;
      end
      want = expected_targets.pop_front();
      if (chan !== want.fan_channel)
        report($sformatf("fan_channel %0d, expected %0d", chan, want.fan_channel));
      if (rpm !== want.rpm_target)
        report($sformatf("rpm_target %0d, expected %0d", rpm, want.rpm_target));
      if (lvl !== want.new_level)
        report($sformatf("new_level %0d, expected %0d", lvl, want.new_level));
      if (data[OUT_DATA_W-1:CHAN_W+RPM_W+LVL_W] !== '0)
        report($sformatf("padding bits not zero in data %h", data));
    endtask
  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top testbench of the fan level table with hysteresis: stimulus, pacing and checks.
`timescale 1ns / 1ps

module tb_top;
  import flht_pkg::*;
  import flht_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SAMPLES_PER_PHASE = 250;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [REG_W-1:0]      cfg_data = '0;

  level_table_scoreboard sb = new();

  logic [REG_W-1:0] cfg_words [NUM_REGS];
  int               cycle_count = 0;
  int               burst_left = 0;
  int               walk_temp = 0;
  int               settings_used = 1;
  rx_mode_t         rx_mode = RX_OPEN;
  int               rx_left = 0;

  fan_level_hysteresis_table u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard limit on the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d targets pending", cycle_count,
               sb.pending());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // The receiver switches between stall patterns at random.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(5, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    m_tready <= 1'b1;
      RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
      RX_BLOCKED: m_tready <= (rx_left % 16 == 0);
      default:    m_tready <= 1'b1;
    endcase
  end

  // Note each sample transfer and check each result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_sample(s_tdata[TEMP_W-1:0], s_tdata[TEMP_W +: CHAN_W],
                       s_tdata[TEMP_W+CHAN_W +: PWR_W]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  // Offer one sample and hold it until its transfer; gaps fall between bursts.
  task automatic send_sample(input logic signed [TEMP_W-1:0] temp,
                             input logic [CHAN_W-1:0] chan, input logic [PWR_W-1:0] pwr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-TEMP_W-CHAN_W-PWR_W){1'b0}}, pwr, chan, temp};
    do @(posedge clk); while (!s_tready);
  endtask

  // Wait until every queued target has come out and the block has settled.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the whole table from cfg_words, one register per cycle.
  task automatic apply_table();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[IDX_W-1:0];
      cfg_data <= cfg_words[i];
      sb.write_register(i[IDX_W-1:0], cfg_words[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Uniform threshold bytes and speeds; inverted swaps the on and off extremes.
  task automatic load_extreme(input bit inverted);
    cfg_words[REG_ON_LOW] = inverted ? 32'h7F7F_7F7F : 32'h8080_8080;
    cfg_words[REG_ON_HIGH] = cfg_words[REG_ON_LOW];
    cfg_words[REG_OFF_LOW] = inverted ? 32'h8080_8080 : 32'h7F7F_7F7F;
    cfg_words[REG_OFF_HIGH] = cfg_words[REG_OFF_LOW];
    for (int k = 0; k < 4; k++)
      cfg_words[REG_SPEED_01 + k] = inverted ? 32'h0000_0000 : 32'hFFFF_FFFF;
    apply_table();
  endtask

  // A rising on curve with off thresholds a few degrees below, random speeds.
  task automatic load_ramp();
    int cur;
    int lvl_on;
    cur = int'($urandom_range(0, 40)) - 20;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cur = cur + int'($urandom_range(3, 12));
      lvl_on = cur;
      cfg_words[REG_ON_LOW + i / 4][(i % 4) * 8 +: 8] = lvl_on[7:0];
      lvl_on = cur - int'($urandom_range(1, 10));
      cfg_words[REG_OFF_LOW + i / 4][(i % 4) * 8 +: 8] = lvl_on[7:0];
    end
    for (int k = 0; k < 4; k++)
      cfg_words[REG_SPEED_01 + k] = $urandom();
    apply_table();
  endtask

  // Mostly running samples that wander in temperature, some suspended, a few ignored.
  task automatic run_random(input int count);
    int                sent;
    int                pick;
    logic [PWR_W-1:0]  pwr;
    logic [CHAN_W-1:0] chan;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 72)
        pwr = PWR_RUNNING;
      else if (pick < 88)
        pwr = PWR_SUSPENDED;
      else if (pick < 94)
        pwr = PWR_OTHER;
      else
        pwr = PWR_UNUSED;
      chan = ($urandom_range(0, 9) < 6) ? '0 : CHAN_W'($urandom_range(1, 3));
      if ($urandom_range(0, 9) == 0)
        walk_temp = int'($urandom_range(0, 255)) - 128;
      else
        walk_temp = walk_temp + int'($urandom_range(0, 16)) - 8;
      if (walk_temp > 127)
        walk_temp = 127;
      if (walk_temp < -128)
        walk_temp = -128;
      send_sample(walk_temp[TEMP_W-1:0], chan, pwr);
      if (pwr == PWR_RUNNING || pwr == PWR_SUSPENDED)
        sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples on the reset table: equal, top, bottom, ignored states.
    send_sample(0, 0, PWR_RUNNING);
    send_sample(37, 0, PWR_RUNNING);
    send_sample(127, 0, PWR_RUNNING);
    send_sample(127, 1, PWR_RUNNING);
    send_sample(126, 2, PWR_RUNNING);
    send_sample(100, 3, PWR_SUSPENDED);
    send_sample(50, 0, PWR_OTHER);
    send_sample(60, 0, PWR_UNUSED);
    send_sample(-128, 0, PWR_RUNNING);
    send_sample(-128, 3, PWR_RUNNING);
    send_sample(-127, 0, PWR_RUNNING);
    send_sample(-128, 1, PWR_SUSPENDED);
    send_sample(45, 0, PWR_RUNNING);
    send_sample(40, 0, PWR_RUNNING);
    send_sample(35, 0, PWR_RUNNING);
    send_sample(30, 0, PWR_RUNNING);
    send_sample(29, 0, PWR_RUNNING);
    send_sample(127, 0, PWR_SUSPENDED);
    send_sample(127, 0, PWR_RUNNING);
    send_sample(0, 3, PWR_UNUSED);
    run_random(SAMPLES_PER_PHASE);

    // Extreme tables: everything walks to the ends, then nothing moves at all.
    wait_idle();
    load_extreme(1'b0);
    run_random(SAMPLES_PER_PHASE);
    wait_idle();
    load_extreme(1'b1);
    run_random(SAMPLES_PER_PHASE);

    // Realistic curves and pure noise in every register.
    wait_idle();
    load_ramp();
    run_random(SAMPLES_PER_PHASE);
    wait_idle();
    for (int k = 0; k < NUM_REGS; k++)
      cfg_words[k] = $urandom();
    apply_table();
    run_random(SAMPLES_PER_PHASE);
    wait_idle();
    load_ramp();
    run_random(SAMPLES_PER_PHASE);

    wait_idle();
    $display("tb_top: %0d results checked across %0d fan tables", sb.checked, settings_used);
    $display("tb_top: %0d walks reached the top level, %0d fell back to level 0",
             sb.top_hits, sb.floor_hits);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d mismatches, %0d targets left over", sb.mismatches, sb.pending());
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
